// ===== sv/drum_step_sequencer_defines.svh =====
// Assertion macros shared by the drum step sequencer RTL.
// Depends on nothing; included by drum_step_sequencer, which carries the assertions.
`ifndef DRUM_STEP_SEQUENCER_DEFINES_SVH
`define DRUM_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drum step sequencer check failed");

// Next-cycle implication, disabled while reset is high.
`define DSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drum step sequencer check failed");

`endif

// ===== sv/dss_pkg.sv =====
// Types, constants and helper functions of the drum step sequencer.
// Used by dss_div and drum_step_sequencer; depends on nothing.
package dss_pkg;

  localparam int NUM_TRACKS     = 8;
  localparam int MAX_DIVISION   = 16;
  localparam int POSITION_BITS  = 24;
  localparam int TRACK_BITS     = 3;
  localparam int STEP_BITS      = 6;
  localparam int STEP_SLOTS     = 64;
  localparam int COUNT_BITS     = 7;
  localparam int DIV_FIELD_BITS = 5;
  localparam int PACKED_TRACKS  = 8;
  localparam int VEL_BITS       = 7;
  localparam int PROD_BITS      = POSITION_BITS + COUNT_BITS;
  localparam int ITER_BITS      = 3;
  localparam int PAT_DEPTH      = NUM_TRACKS * STEP_SLOTS;
  localparam int PAT_ADDR_BITS  = TRACK_BITS + STEP_BITS;
  localparam int CLR_BITS       = PAT_ADDR_BITS + 1;
  localparam int TRK_WORD_BITS  = STEP_BITS + 1;

  localparam int LEN_BITS       = 24;
  localparam int DIVS_BITS      = DIV_FIELD_BITS * PACKED_TRACKS;
  localparam int MASK_BITS      = PACKED_TRACKS;
  localparam int CFG_DATA_BITS  = 40;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_DIVS   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_MASK  = 2'd2;

  localparam logic [LEN_BITS-1:0]  LOOP_LENGTH_RESET = 24'd352800;
  localparam logic [DIVS_BITS-1:0] TRACK_DIVS_RESET  = 40'd141872468100;
  localparam logic [MASK_BITS-1:0] SAMPLE_MASK_RESET = 8'd0;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic                     playing;
    logic [TRACK_BITS-1:0]    write_track;
    logic [STEP_BITS-1:0]     write_step;
    logic [VEL_BITS-1:0]      write_velocity;
  } in_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0]    track;
    logic [VEL_BITS-1:0]      velocity;
    logic                     use_sample;
    logic [STEP_BITS-1:0]     step_index;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic                     done;
    logic [STEP_BITS-1:0]     quo;
  } div_res_t;

  // Steps per loop for a raw division field: zero counts as one, large values saturate.
  function automatic logic [COUNT_BITS-1:0] div_steps(input logic [DIV_FIELD_BITS-1:0] f);
    logic [DIV_FIELD_BITS-1:0] d;
    d = f;
    if (d == '0) d = DIV_FIELD_BITS'(1);
    if (d > DIV_FIELD_BITS'(MAX_DIVISION)) d = DIV_FIELD_BITS'(MAX_DIVISION);
    return COUNT_BITS'({d, 2'b00});
  endfunction

endpackage

// ===== sv/drum_step_sequencer.sv =====
// Drum step sequencer: a playing tick walks the tracks in turn (multiply, divide, step
// compare, and a pattern read where the step changed); the input stays busy until the tick
// closes, longer while triggers stall. Writes and ticks that are not playing leave it idle.
// A trigger waits one behind until the next one is found or the tick closes, then leaves.
// After reset a clearing pass zeroes the pattern and step memories; no transaction is taken then.
// Depends on dss_pkg, dss_ram, dss_div and drum_step_sequencer_defines.svh.
`include "drum_step_sequencer_defines.svh"

module drum_step_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [dss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  dss_pkg::in_t                       cmd_data,
  output logic                               trig_valid,
  input  logic                               trig_ready,
  output dss_pkg::out_t                      trig_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_PAT   = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]                           state;
  logic [2:0]                           state_next;
  logic [dss_pkg::LEN_BITS-1:0]         loop_length;
  logic [dss_pkg::DIVS_BITS-1:0]        track_divisions;
  logic [dss_pkg::MASK_BITS-1:0]        sample_loaded_mask;
  logic [dss_pkg::POSITION_BITS-1:0]    pos;
  logic [dss_pkg::LEN_BITS-1:0]         len_eff;
  logic [dss_pkg::POSITION_BITS:0]      pos_inc;
  logic [dss_pkg::TRACK_BITS-1:0]       trk;
  logic [dss_pkg::CLR_BITS-1:0]         clr_cnt;
  logic                                 pend_valid;
  dss_pkg::out_t                        pend;
  dss_pkg::div_res_t                    div_res;
  logic [dss_pkg::COUNT_BITS-1:0]       steps;

  logic                                 pat_we;
  logic [dss_pkg::PAT_ADDR_BITS-1:0]    pat_waddr;
  logic [dss_pkg::VEL_BITS-1:0]         pat_wdata;
  logic [dss_pkg::PAT_ADDR_BITS-1:0]    pat_raddr;
  logic [dss_pkg::VEL_BITS-1:0]         pat_rdata;
  logic                                 tr_we;
  logic [dss_pkg::TRACK_BITS-1:0]       tr_waddr;
  logic [dss_pkg::TRK_WORD_BITS-1:0]    tr_wdata;
  logic [dss_pkg::TRK_WORD_BITS-1:0]    tr_rdata;

  logic                                 accept;
  logic                                 out_free;
  logic                                 changed;
  logic                                 hit;
  logic                                 last_trk;
  logic                                 trig_load;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign out_free  = !trig_valid || trig_ready;
  assign len_eff   = (loop_length == '0) ? dss_pkg::LEN_BITS'(1) : loop_length;
  assign pos_inc   = {1'b0, pos} + (dss_pkg::POSITION_BITS + 1)'(1);
  assign steps     = dss_pkg::div_steps(
                       track_divisions[dss_pkg::DIV_FIELD_BITS*trk +: dss_pkg::DIV_FIELD_BITS]);
  // Bit STEP_BITS of a step word is its valid flag; the clearing pass leaves it low.
  assign changed   = !tr_rdata[dss_pkg::STEP_BITS] ||
                     (tr_rdata[dss_pkg::STEP_BITS-1:0] != div_res.quo);
  assign hit       = (pat_rdata != '0);
  assign last_trk  = (trk == dss_pkg::TRACK_BITS'(dss_pkg::NUM_TRACKS - 1));
  assign trig_load = pend_valid && out_free &&
                     ((state == S_PAT && hit) || state == S_FLUSH);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length        <= dss_pkg::LOOP_LENGTH_RESET;
      track_divisions    <= dss_pkg::TRACK_DIVS_RESET;
      sample_loaded_mask <= dss_pkg::SAMPLE_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dss_pkg::REG_LOOP_LENGTH: loop_length        <= cfg_data[dss_pkg::LEN_BITS-1:0];
        dss_pkg::REG_TRACK_DIVS:  track_divisions    <= cfg_data[dss_pkg::DIVS_BITS-1:0];
        dss_pkg::REG_SAMPLE_MASK: sample_loaded_mask <= cfg_data[dss_pkg::MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Memory ports: the clearing pass owns both write ports until it ends.
  always_comb begin
    pat_we    = 1'b0;
    pat_waddr = {cmd_data.write_track, cmd_data.write_step};
    pat_wdata = cmd_data.write_velocity;
    tr_we     = 1'b0;
    tr_waddr  = trk;
    tr_wdata  = {1'b1, div_res.quo};
    if (state == S_CLEAR) begin
      pat_we    = 1'b1;
      pat_waddr = clr_cnt[dss_pkg::PAT_ADDR_BITS-1:0];
      pat_wdata = '0;
      tr_we     = 1'b1;
      tr_waddr  = clr_cnt[dss_pkg::TRACK_BITS-1:0];
      tr_wdata  = '0;
    end else if (accept && cmd_data.cmd == dss_pkg::CMD_WRITE) begin
      pat_we = 1'b1;
    end else if (state == S_CMP && changed) begin
      tr_we = 1'b1;
    end
  end

  assign pat_raddr = {trk, div_res.quo};

  dss_ram #(
    .WIDTH (dss_pkg::VEL_BITS),
    .DEPTH (dss_pkg::PAT_DEPTH)
  ) u_pattern (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  dss_ram #(
    .WIDTH (dss_pkg::TRK_WORD_BITS),
    .DEPTH (dss_pkg::NUM_TRACKS)
  ) u_track_step (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (tr_wdata),
    .raddr (trk),
    .rdata (tr_rdata)
  );

  dss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MUL),
    .pos   (pos),
    .steps (steps),
    .len   (len_eff),
    .res   (div_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == dss_pkg::CLR_BITS'(dss_pkg::PAT_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && cmd_data.cmd == dss_pkg::CMD_TICK && cmd_data.playing) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (div_res.done) state_next = S_CMP;
      end
      S_CMP: begin
        if (changed) state_next = S_PAT;
        else         state_next = last_trk ? S_FLUSH : S_MUL;
      end
      S_PAT: begin
        if (!hit || !pend_valid || out_free) state_next = last_trk ? S_FLUSH : S_MUL;
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      pos        <= '0;
      trk        <= '0;
      pend_valid <= 1'b0;
      trig_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (trig_load) begin
        trig_valid <= 1'b1;
      end else if (trig_ready) begin
        trig_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + dss_pkg::CLR_BITS'(1);
        S_IDLE: begin
          if (accept && cmd_data.cmd == dss_pkg::CMD_TICK && cmd_data.playing) begin
            pos <= (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[dss_pkg::POSITION_BITS-1:0];
            trk <= '0;
          end
        end
        S_CMP: begin
          if (!changed && !last_trk) trk <= trk + dss_pkg::TRACK_BITS'(1);
        end
        S_PAT: begin
          // A trigger waits in the pending slot until the next one shows it is not last.
          if (hit && (!pend_valid || out_free)) pend_valid <= 1'b1;
          if ((!hit || !pend_valid || out_free) && !last_trk) begin
            trk <= trk + dss_pkg::TRACK_BITS'(1);
          end
        end
        S_FLUSH: begin
          if (pend_valid && out_free) pend_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers. The pending slot always holds last low.
  always_ff @(posedge clk) begin
    if (state == S_PAT && hit && (!pend_valid || out_free)) begin
      if (pend_valid) begin
        trig_data <= pend;
      end
      pend.track      <= trk;
      pend.velocity   <= pat_rdata;
      pend.use_sample <= sample_loaded_mask[trk];
      pend.step_index <= div_res.quo;
      pend.last       <= 1'b0;
    end else if (state == S_FLUSH && pend_valid && out_free) begin
      trig_data <= {pend.track, pend.velocity, pend.use_sample, pend.step_index, 1'b1};
    end
  end

  `DSS_ASSERT_IMPL(a_trig_has_velocity, clk, rst, trig_valid, trig_data.velocity != '0)
  `DSS_ASSERT_IMPL(a_pos_inside_loop, clk, rst, state == S_MUL, pos < len_eff)
  `DSS_ASSERT_IMPL(a_idle_no_pending, clk, rst, cmd_ready, !pend_valid)
  `DSS_ASSERT_IMPL(a_step_write_owner, clk, rst, tr_we, state == S_CMP || state == S_CLEAR)
  `DSS_ASSERT_IMPL(a_div_done_waited, clk, rst, div_res.done, state == S_DIV)

endmodule

// ===== sv/dss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the pattern store and the per-track step words.
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dss_div.sv =====
// Step computation unit: one multiply, then a restoring divide, one quotient bit a cycle.
// Depends on dss_pkg.
module dss_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dss_pkg::POSITION_BITS-1:0] pos,
  input  logic [dss_pkg::COUNT_BITS-1:0]    steps,
  input  logic [dss_pkg::LEN_BITS-1:0]      len,
  output dss_pkg::div_res_t                 res
);

  logic [dss_pkg::PROD_BITS-1:0] rem;
  logic [dss_pkg::PROD_BITS-1:0] dvs;
  logic [dss_pkg::STEP_BITS-1:0] quo;
  logic [dss_pkg::ITER_BITS-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic                          fits;

  assign fits = (rem >= dvs);

  // The product stays below len * 64, so six quotient bits are enough.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == dss_pkg::ITER_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dss_pkg::PROD_BITS'(pos) * dss_pkg::PROD_BITS'(steps);
      dvs <= dss_pkg::PROD_BITS'(len) << (dss_pkg::STEP_BITS - 1);
      quo <= '0;
      cnt <= dss_pkg::ITER_BITS'(dss_pkg::STEP_BITS);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dvs;
      end
      quo <= {quo[dss_pkg::STEP_BITS-2:0], fits};
      dvs <= dvs >> 1;
      cnt <= cnt - dss_pkg::ITER_BITS'(1);
    end
  end

  assign res.done = done;
  assign res.quo  = quo;

endmodule

// ===== tb/sv/tb_drum_step_sequencer.sv =====
// Self-checking testbench for drum_step_sequencer: a stimulus table, then random
// command phases under several register settings, checked against a local model.
// Depends on dss_pkg and the drum_step_sequencer RTL.
module tb_drum_step_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import dss_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int STEPS_PER_DIVISION = 4;
  localparam int SETTLE_CYCLES      = 200;
  localparam int DRAIN_LIMIT        = 20000;
  localparam int HOLD_CYCLES        = 600;
  localparam int NUM_PHASES         = 8;
  localparam int NUM_DIRECTED       = 12;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_ready;
  in_t                       cmd_data  = '0;
  logic                      trig_valid;
  logic                      trig_ready = 1'b0;
  out_t                      trig_data;

  drum_step_sequencer i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig_data  (trig_data)
  );

  always #1 clk = ~clk;

  // Local copy of the sequencer state and registers.
  logic [LEN_BITS-1:0]      model_len  = LOOP_LENGTH_RESET;
  logic [DIVS_BITS-1:0]     model_divs = TRACK_DIVS_RESET;
  logic [MASK_BITS-1:0]     model_mask = SAMPLE_MASK_RESET;
  logic [POSITION_BITS-1:0] play_pos   = '0;
  logic [STEP_BITS-1:0]     held_step  [NUM_TRACKS];
  logic                     held_valid [NUM_TRACKS];
  logic [VEL_BITS-1:0]      pattern    [PAT_DEPTH];

  out_t tick_triggers[$];
  out_t pending_triggers[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  int hold_left   = 0;
  int fail_count  = 0;
  int n_ticks     = 0;
  int n_writes    = 0;
  int n_triggers  = 0;

  typedef struct {
    in_t  c;
    int   n_typed;  // -1: take the model's triggers
    out_t typed;
  } directed_row_t;

  function automatic in_t make_cmd(logic cmd, logic playing, int trk, int step, int vel);
    in_t c;
    c.cmd            = cmd;
    c.playing        = playing;
    c.write_track    = TRACK_BITS'(trk);
    c.write_step     = STEP_BITS'(step);
    c.write_velocity = VEL_BITS'(vel);
    return c;
  endfunction

  // Applies one command to the local state; the triggers it fires land in tick_triggers.
  task automatic advance_sequencer(input in_t c);
    longint unsigned len;
    longint unsigned nxt;
    longint unsigned steps;
    longint unsigned step;
    logic [DIV_FIELD_BITS-1:0] div;
    logic [STEP_BITS-1:0] st;
    logic [VEL_BITS-1:0] vel;
    out_t hit;
    tick_triggers.delete();
    if (c.cmd == CMD_WRITE) begin
      pattern[{c.write_track, c.write_step}] = c.write_velocity;
      return;
    end
    if (!c.playing) return;
    len = (model_len == '0) ? 1 : model_len;
    nxt = play_pos + 1;
    if (nxt >= len) nxt = 0;
    play_pos = POSITION_BITS'(nxt);
    for (int t = 0; t < NUM_TRACKS; t++) begin
      div = model_divs[t*DIV_FIELD_BITS +: DIV_FIELD_BITS];
      if (div == '0) div = DIV_FIELD_BITS'(1);
      if (div > MAX_DIVISION) div = DIV_FIELD_BITS'(MAX_DIVISION);
      steps = div * STEPS_PER_DIVISION;
      step  = (play_pos * steps) / len;
      st    = step[STEP_BITS-1:0];
      if (!held_valid[t] || held_step[t] != st) begin
        held_step[t]  = st;
        held_valid[t] = 1'b1;
        vel = pattern[t*STEP_SLOTS + st];
        if (vel != '0) begin
          hit.track      = TRACK_BITS'(t);
          hit.velocity   = vel;
          hit.use_sample = model_mask[t];
          hit.step_index = st;
          hit.last       = 1'b0;
          tick_triggers.push_back(hit);
        end
      end
    end
    if (tick_triggers.size() > 0) tick_triggers[tick_triggers.size()-1].last = 1'b1;
  endtask

  task automatic send_command(input in_t c, input int n_typed, input out_t typed);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    advance_sequencer(c);
    if (n_typed < 0) begin
      foreach (tick_triggers[i]) pending_triggers.push_back(tick_triggers[i]);
    end else if (n_typed == 1) begin
      pending_triggers.push_back(typed);
    end
    if (c.cmd == CMD_WRITE) n_writes++;
    else n_ticks++;
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LOOP_LENGTH: model_len  = data[LEN_BITS-1:0];
      REG_TRACK_DIVS:  model_divs = data[DIVS_BITS-1:0];
      REG_SAMPLE_MASK: model_mask = data[MASK_BITS-1:0];
      default: ;
    endcase
  endtask

  // Stops offering, waits up to a limit for every expected trigger, then lets a quiet tick finish.
  task automatic drain_pipeline();
    int waited;
    waited = 0;
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_triggers.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (pending_triggers.size() > 0) begin
      $display("%0t: trigger track %0d step %0d expected, got none", $time,
               pending_triggers[0].track, pending_triggers[0].step_index);
      void'(pending_triggers.pop_front());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void set_idling(int p);
    if (p <= 3) begin
      tx_idle_pct = 32;
      rx_idle_pct = 76;
    end else if (p <= 6) begin
      tx_idle_pct = 76;
      rx_idle_pct = 32;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endfunction

  // Each phase opens with a burst of pattern writes so that the ticks find hits.
  function automatic in_t random_command(int idx);
    in_t c;
    c.write_track    = TRACK_BITS'($urandom_range(7));
    c.write_step     = ($urandom_range(99) < 60) ? STEP_BITS'($urandom_range(15))
                                                 : STEP_BITS'($urandom_range(63));
    c.write_velocity = ($urandom_range(99) < 15) ? '0 : VEL_BITS'($urandom_range(127, 1));
    c.playing        = ($urandom_range(99) < 90);
    c.cmd            = (idx < 12 || $urandom_range(99) < 20) ? CMD_WRITE : CMD_TICK;
    return c;
  endfunction

  task automatic run_phase(input int p);
    logic [LEN_BITS-1:0]  len;
    logic [DIVS_BITS-1:0] divs;
    logic [MASK_BITS-1:0] mask;
    int n_items;
    divs = {8'($urandom), 32'($urandom)};
    mask = 8'($urandom);
    case (p)
      1: begin
        len = 24'd16;
        divs = {5'd2, 5'd8, 5'd4, 5'd1, 5'd17, 5'd16, 5'd31, 5'd0};
        mask = 8'hFF;
        n_items = 60;
      end
      2: begin
        len = 24'd200;
        divs = '1;
        mask = 8'h00;
        n_items = 60;
      end
      3: begin
        len = 24'd64;
        divs = '1;
        n_items = 50;
      end
      4: begin
        // A short loop; where the previous phase left the position beyond it, the loop wraps early.
        len = 24'd5;
        n_items = 50;
      end
      5: begin
        len = '0;
        divs = '0;
        mask = 8'hA5;
        n_items = 20;
      end
      6: begin
        len = '1;
        mask = 8'h5A;
        n_items = 20;
      end
      7: begin
        len = 24'd1;
        divs = TRACK_DIVS_RESET;
        n_items = 20;
      end
      default: begin
        len = 24'd24;
        n_items = 80;
      end
    endcase
    set_idling(p);
    write_register(REG_LOOP_LENGTH, {16'($urandom), len});
    write_register(REG_TRACK_DIVS, divs);
    write_register(REG_SAMPLE_MASK, {32'($urandom), mask});
    write_register(REG_UNUSED, {8'($urandom), 32'($urandom)});
    @(negedge clk);
    cfg_we <= 1'b0;
    if (p == 1) hold_req = 1'b1;
    for (int i = 0; i < n_items; i++) send_command(random_command(i), -1, '0);
    drain_pipeline();
  endtask

  // Trigger side: random back-pressure plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        trig_ready <= 1'b0;
      end else begin
        trig_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: trigger %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && trig_valid && trig_ready) begin
      n_triggers++;
      if (pending_triggers.size() == 0) begin
        $display("%0t: trigger expected none, got track %0d velocity %0d step %0d", $time,
                 trig_data.track, trig_data.velocity, trig_data.step_index);
        fail_count++;
      end else begin
        want = pending_triggers.pop_front();
        flag_field("track", 8'(want.track), 8'(trig_data.track));
        flag_field("velocity", 8'(want.velocity), 8'(trig_data.velocity));
        flag_field("use_sample", 8'(want.use_sample), 8'(trig_data.use_sample));
        flag_field("step_index", 8'(want.step_index), 8'(trig_data.step_index));
        flag_field("last", 8'(want.last), 8'(trig_data.last));
      end
    end
  end

  initial begin
    directed_row_t rows [NUM_DIRECTED];
    for (int t = 0; t < NUM_TRACKS; t++) begin
      held_step[t]  = '0;
      held_valid[t] = 1'b0;
    end
    for (int a = 0; a < PAT_DEPTH; a++) pattern[a] = '0;

    // Under the reset loop length every track sits on step 0 for a long while.
    rows[0]  = '{make_cmd(CMD_TICK,  1'b0, 7, 63, 127), 0, '0};
    rows[1]  = '{make_cmd(CMD_WRITE, 1'b1, 0, 0, 127), 0, '0};
    rows[2]  = '{make_cmd(CMD_WRITE, 1'b0, 7, 63, 127), 0, '0};
    rows[3]  = '{make_cmd(CMD_WRITE, 1'b0, 3, 63, 0), 0, '0};
    rows[4]  = '{make_cmd(CMD_TICK,  1'b1, 0, 0, 0), 1, out_t'{3'd0, 7'd127, 1'b0, 6'd0, 1'b1}};
    rows[5]  = '{make_cmd(CMD_TICK,  1'b1, 7, 63, 127), 0, '0};
    rows[6]  = '{make_cmd(CMD_WRITE, 1'b0, 7, 0, 1), 0, '0};
    rows[7]  = '{make_cmd(CMD_WRITE, 1'b1, 5, 42, 85), 0, '0};
    rows[8]  = '{make_cmd(CMD_WRITE, 1'b0, 2, 21, 42), 0, '0};
    rows[9]  = '{make_cmd(CMD_TICK,  1'b0, 0, 0, 0), 0, '0};
    rows[10] = '{make_cmd(CMD_TICK,  1'b1, 2, 21, 42), -1, '0};
    rows[11] = '{make_cmd(CMD_WRITE, 1'b0, 0, 0, 0), 0, '0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(0);
    foreach (rows[i]) send_command(rows[i].c, rows[i].n_typed, rows[i].typed);
    drain_pipeline();
    for (int p = 1; p <= NUM_PHASES; p++) run_phase(p);

    $display("Run covered %0d ticks and %0d pattern writes over %0d register settings,",
             n_ticks, n_writes, NUM_PHASES + 1);
    $display("with %0d triggers checked under three idling mixes and one long stall.",
             n_triggers);
    if (fail_count == 0) begin
      $display("tb_drum_step_sequencer: clean");
    end else begin
      $display("tb_drum_step_sequencer: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d triggers still expected.", pending_triggers.size());
    $display("tb_drum_step_sequencer: errors");
    $finish;
  end

endmodule
